@@ rtl/albt_pkg.sv @@
// ----------------------------------------------------------------------------
// albt_pkg
// shared types and codes of the aging lru buffer table
// ----------------------------------------------------------------------------
package albt_pkg;

  localparam logic [2:0] ACT_LOOKUP = 3'd0;
  localparam logic [2:0] ACT_INSERT = 3'd1;
  localparam logic [2:0] ACT_TICK   = 3'd2;
  localparam logic [2:0] ACT_EVICT  = 3'd3;
  localparam logic [2:0] ACT_FLUSH  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // request travelling down the row of cells, with what it has found so far
  typedef struct packed {
    logic        active;
    logic [2:0]  action;
    logic [7:0]  file_id;
    logic [15:0] block_num;
    logic        dirty_in;
    logic        found;
    logic [5:0]  slot;
    logic [7:0]  rfile;
    logic [15:0] rblock;
    logic        rdirty;
  } probe_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] slot;
  } kill_t;

  typedef struct packed {
    logic        valid;
    logic [5:0]  slot;
    logic [7:0]  file_id;
    logic [15:0] block_num;
  } emit_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [7:0]  file_id;
    logic [15:0] block_num;
    logic        write_back;
    logic        last;
  } result_t;

endpackage

@@ rtl/albt_cell.sv @@
// ----------------------------------------------------------------------------
// albt_cell
// one table entry; acts on the passing request and hands it to the next cell
// ----------------------------------------------------------------------------
module albt_cell import albt_pkg::*; #(
  parameter int AGE_BITS = 16,
  parameter int IDX      = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  probe_t              pin,
  input  logic [AGE_BITS-1:0] age_in,
  input  kill_t               kill,
  output probe_t              pout,
  output logic [AGE_BITS-1:0] age_out,
  output emit_t               emit
);

  logic                valid, valid_next;
  logic [7:0]          efile, efile_next;
  logic [15:0]         eblock, eblock_next;
  logic [AGE_BITS-1:0] eage, eage_next;
  logic                edirty, edirty_next;
  probe_t              nxt;
  logic [AGE_BITS-1:0] nage;

  always_comb begin
    nxt         = pin;
    nage        = age_in;
    valid_next  = valid;
    efile_next  = efile;
    eblock_next = eblock;
    eage_next   = eage;
    edirty_next = edirty;
    emit        = '0;
    if (en && pin.active) begin
      case (pin.action)
        ACT_LOOKUP: begin
          if (!pin.found && valid && efile == pin.file_id && eblock == pin.block_num) begin
            nxt.found  = 1'b1;
            nxt.slot   = 6'(IDX);
            nxt.rfile  = efile;
            nxt.rblock = eblock;
          end
        end
        ACT_INSERT: begin
          if (!pin.found && !valid) begin
            valid_next  = 1'b1;
            efile_next  = pin.file_id;
            eblock_next = pin.block_num;
            eage_next   = '0;
            edirty_next = pin.dirty_in;
            nxt.found   = 1'b1;
            nxt.slot    = 6'(IDX);
          end
        end
        ACT_TICK: begin
          if (valid && !(&eage)) eage_next = eage + 1'b1;
        end
        ACT_EVICT: begin
          // strict compare keeps the lowest slot on a tie
          if (valid && (!pin.found || eage > age_in)) begin
            nxt.found  = 1'b1;
            nxt.slot   = 6'(IDX);
            nxt.rfile  = efile;
            nxt.rblock = eblock;
            nxt.rdirty = edirty;
            nage       = eage;
          end
        end
        ACT_FLUSH: begin
          if (valid && edirty) begin
            edirty_next    = 1'b0;
            emit.valid     = 1'b1;
            emit.slot      = 6'(IDX);
            emit.file_id   = efile;
            emit.block_num = eblock;
          end
        end
        default: ;
      endcase
    end
    if (kill.valid && kill.slot == 6'(IDX)) valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      pout.active <= 1'b0;
    end else begin
      valid <= valid_next;
      if (en) pout.active <= pin.active;
    end
    efile  <= efile_next;
    eblock <= eblock_next;
    eage   <= eage_next;
    edirty <= edirty_next;
    if (en) begin
      pout.action    <= nxt.action;
      pout.file_id   <= nxt.file_id;
      pout.block_num <= nxt.block_num;
      pout.dirty_in  <= nxt.dirty_in;
      pout.found     <= nxt.found;
      pout.slot      <= nxt.slot;
      pout.rfile     <= nxt.rfile;
      pout.rblock    <= nxt.rblock;
      pout.rdirty    <= nxt.rdirty;
      age_out        <= nage;
    end
  end

endmodule

@@ rtl/aging_lru_buffer_table.sv @@
// ----------------------------------------------------------------------------
// aging_lru_buffer_table
// buffer-pool table of cached blocks with aging, eviction and flush
// ----------------------------------------------------------------------------
// Every request walks the row of ENTRIES cells, one cell per cycle while the
// output side does not stall. The request is registered at the head of the
// row, in each cell in turn and then in the output register; a new request
// is taken only once the last one has left the row. Each cell acts on the
// request as it passes (first match, first free slot, age increment, running
// maximum of age, dirty clear) and the end of the row decides the result.
// Flush results come out while the walk goes on; when the output side stalls
// the whole row waits. No clearing pass is needed after reset.
module aging_lru_buffer_table import albt_pkg::*; #(
  parameter int ENTRIES  = 64,
  parameter int AGE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [7:0]  file_id,
  input  logic [15:0] block_num,
  input  logic        dirty_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  slot,
  output logic [7:0]  out_file,
  output logic [15:0] out_block,
  output logic        write_back,
  output logic        last
);

  // request registers between cells; probe[ENTRIES] is the end of the row
  probe_t              probe [ENTRIES+1];
  logic [AGE_BITS-1:0] age   [ENTRIES+1];
  emit_t               emits [ENTRIES];
  emit_t               emit_any;
  kill_t               kill;

  logic    busy;
  logic    en;
  logic    hold_valid;
  emit_t   hold;
  result_t res, fin;
  logic    accept;
  logic    done;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;
  // the row moves only when the output register can take a result
  assign en       = !out_valid || !out_stall;
  assign done     = en && probe[ENTRIES].active;

  // head of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      probe[0].active <= 1'b0;
    end else if (accept) begin
      probe[0].active <= 1'b1;
    end else if (en) begin
      probe[0].active <= 1'b0;
    end
    if (accept) begin
      probe[0].action    <= action;
      probe[0].file_id   <= file_id;
      probe[0].block_num <= block_num;
      probe[0].dirty_in  <= dirty_in;
      probe[0].found     <= 1'b0;
      probe[0].slot      <= '0;
      probe[0].rfile     <= '0;
      probe[0].rblock    <= '0;
      probe[0].rdirty    <= 1'b0;
    end
  end
  assign age[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    albt_cell #(.AGE_BITS(AGE_BITS), .IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .pin     (probe[i]),
      .age_in  (age[i]),
      .kill    (kill),
      .pout    (probe[i+1]),
      .age_out (age[i+1]),
      .emit    (emits[i])
    );
  end

  // only the cell holding the request can emit, so an or of all is a select
  always_comb begin
    emit_any = '0;
    for (int i = 0; i < ENTRIES; i++) emit_any = emit_any | emits[i];
  end

  // the evicted entry is dropped as the request leaves the row
  assign kill.valid = done && probe[ENTRIES].action == ACT_EVICT && probe[ENTRIES].found;
  assign kill.slot  = probe[ENTRIES].slot;

  // final result of the request
  always_comb begin
    fin      = '0;
    fin.last = 1'b1;
    case (probe[ENTRIES].action)
      ACT_LOOKUP: begin
        if (probe[ENTRIES].found) begin
          fin.slot      = probe[ENTRIES].slot;
          fin.file_id   = probe[ENTRIES].rfile;
          fin.block_num = probe[ENTRIES].rblock;
        end else begin
          fin.status = ST_MISS;
        end
      end
      ACT_INSERT: begin
        if (probe[ENTRIES].found) begin
          fin.slot      = probe[ENTRIES].slot;
          fin.file_id   = probe[ENTRIES].file_id;
          fin.block_num = probe[ENTRIES].block_num;
        end else begin
          fin.status = ST_FULL;
        end
      end
      ACT_EVICT: begin
        if (probe[ENTRIES].found) begin
          fin.slot       = probe[ENTRIES].slot;
          fin.file_id    = probe[ENTRIES].rfile;
          fin.block_num  = probe[ENTRIES].rblock;
          fin.write_back = probe[ENTRIES].rdirty;
        end else begin
          fin.status = ST_EMPTY;
        end
      end
      ACT_FLUSH: begin
        // the last dirty entry waits in the hold register to learn it is last
        if (hold_valid) begin
          fin.slot       = hold.slot;
          fin.file_id    = hold.file_id;
          fin.block_num  = hold.block_num;
          fin.write_back = 1'b1;
        end else begin
          fin.status = ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // an earlier flush entry goes out once a later one shows up
  always_comb begin
    res            = '0;
    res.slot       = hold.slot;
    res.file_id    = hold.file_id;
    res.block_num  = hold.block_num;
    res.write_back = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) busy <= 1'b1;
      else if (done) busy <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (en) begin
        if (emit_any.valid) begin
          hold_valid <= 1'b1;
          if (hold_valid) out_valid <= 1'b1;
        end else if (done) begin
          hold_valid <= 1'b0;
          out_valid  <= 1'b1;
        end
      end
    end
    if (en && emit_any.valid) hold <= emit_any;
    if (en && ((emit_any.valid && hold_valid) || (!emit_any.valid && done))) begin
      if (emit_any.valid) begin
        {status, slot, out_file, out_block, write_back, last} <= res;
      end else begin
        {status, slot, out_file, out_block, write_back, last} <= fin;
      end
    end
  end

endmodule

@@ rtl/albt_checker.sv @@
// ----------------------------------------------------------------------------
// albt_checker
// port-level checks of the aging lru buffer table
// ----------------------------------------------------------------------------
module albt_checker import albt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [5:0]  slot,
  input logic [7:0]  out_file,
  input logic [15:0] out_block,
  input logic        write_back,
  input logic        last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({status, slot, out_file, out_block,
                                                     write_back, last}))
    else $error("stalled result changed");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in flight");

  // error results carry no slot and no writeback
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> slot == '0 && !write_back && last)
    else $error("error result with payload");

  // only flush gives non-final results
  a_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> status == ST_OK && write_back)
    else $error("non-final result that is not a flushed entry");

endmodule

bind aging_lru_buffer_table albt_checker u_albt_checker (.*);
